[src/pcfk_pkg.sv]
package pcfk_pkg;

    localparam int ANG_W   = 16;
    localparam int LEN_W   = 16;
    localparam int POS_W   = 20;
    localparam int TRIG_W  = 16;
    localparam int QTAB_W  = 15;
    localparam int FRAC_W  = 14;
    localparam int LC_W    = 3;
    localparam int REG_W   = 3;
    localparam int NUM_LEN = 4;
    localparam int PROD_W  = LEN_W + QTAB_W;
    localparam int RND_W   = PROD_W - FRAC_W + 1;
    localparam int SUM_W   = POS_W + 2;

    localparam logic [QTAB_W-1:0]         ONE_Q14   = QTAB_W'(16384);
    localparam logic [PROD_W-1:0]         RND_HALF  = PROD_W'(8192);
    localparam logic signed [POS_W-1:0]   SAT_MAX   = 20'sh7FFFF;
    localparam logic signed [POS_W-1:0]   SAT_MIN   = -20'sh80000;
    localparam longint unsigned           PI_Q30    = 64'd3373259426;
    localparam logic [LEN_W-1:0]          LEN_RESET = LEN_W'(256);
    localparam logic [LC_W-1:0]           LC_RESET  = LC_W'(3);

    typedef enum logic [REG_W-1:0] {
        REG_LINK_COUNT   = 3'd0,
        REG_LENGTH_LINK0 = 3'd1,
        REG_LENGTH_LINK1 = 3'd2,
        REG_LENGTH_LINK2 = 3'd3,
        REG_LENGTH_LINK3 = 3'd4
    } t_reg_idx;

    // per-stage flags of one joint transaction
    typedef struct packed {
        logic valid;
        logic last;
        logic ok;
    } t_stage_ctl;

endpackage

[src/pcfk_sine_rom.sv]
module pcfk_sine_rom #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] i_addr_a,
    input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] i_addr_b,
    output logic [pcfk_pkg::QTAB_W-1:0]         o_data_a,
    output logic [pcfk_pkg::QTAB_W-1:0]         o_data_b
);

    typedef logic [pcfk_pkg::QTAB_W-1:0] t_qtab [0:SINE_TABLE_DEPTH];

    localparam longint unsigned ANGLE_DEN = longint'(2 * SINE_TABLE_DEPTH);

    // next odd power of the angle, in Q30
    function automatic longint unsigned next_odd_power(input longint unsigned term,
                                                       input longint unsigned x);
        return (((term * x) >> 30) * x) >> 30;
    endfunction

    // quarter-wave sine in Q1.14, Taylor series to x^13 in Q30
    function automatic t_qtab build_qtab();
        t_qtab             tab;
        longint unsigned   x;
        longint unsigned   term;
        longint            acc;
        longint            v;
        int                k;
        for (k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x    = (pcfk_pkg::PI_Q30 * longint'(k)) / ANGLE_DEN;
            acc  = longint'(x);
            // each term divides by (2n)(2n+1), signs alternate
            term = next_odd_power(x, x) / 64'd6;
            acc  = acc - longint'(term);
            term = next_odd_power(term, x) / 64'd20;
            acc  = acc + longint'(term);
            term = next_odd_power(term, x) / 64'd42;
            acc  = acc - longint'(term);
            term = next_odd_power(term, x) / 64'd72;
            acc  = acc + longint'(term);
            term = next_odd_power(term, x) / 64'd110;
            acc  = acc - longint'(term);
            term = next_odd_power(term, x) / 64'd156;
            acc  = acc + longint'(term);
            if (acc < 0) begin
                acc = 0;
            end
            v = (acc + 32768) >>> 16;
            if (v > 16384) begin
                v = 16384;
            end
            tab[k] = pcfk_pkg::QTAB_W'(v);
        end
        return tab;
    endfunction

    localparam t_qtab QTAB = build_qtab();

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_data_a <= QTAB[i_addr_a];
            o_data_b <= QTAB[i_addr_b];
        end
    end

endmodule

[src/pcfk_axis.sv]
module pcfk_axis (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic [pcfk_pkg::LEN_W-1:0]          i_len,
    input  logic [pcfk_pkg::QTAB_W-1:0]         i_mag,
    input  logic                                i_neg,
    input  pcfk_pkg::t_stage_ctl                i_ctl,
    output logic signed [pcfk_pkg::POS_W-1:0]   o_sum
);

    logic [pcfk_pkg::PROD_W-1:0]        r_prod;
    logic                               r_neg;
    logic signed [pcfk_pkg::POS_W-1:0]  r_acc;
    logic signed [pcfk_pkg::POS_W-1:0]  n_acc;
    logic [pcfk_pkg::PROD_W-1:0]        rounded;
    logic signed [pcfk_pkg::RND_W-1:0]  step;
    logic signed [pcfk_pkg::SUM_W-1:0]  wide;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= pcfk_pkg::PROD_W'(i_len) * pcfk_pkg::PROD_W'(i_mag);
            r_neg  <= i_neg;
        end
    end

    // round half away from zero: round the magnitude, then apply the sign
    always_comb begin
        rounded = (r_prod + pcfk_pkg::RND_HALF) >> pcfk_pkg::FRAC_W;
        step    = r_neg ? -$signed(pcfk_pkg::RND_W'(rounded))
                        :  $signed(pcfk_pkg::RND_W'(rounded));
        wide    = pcfk_pkg::SUM_W'(r_acc) + pcfk_pkg::SUM_W'(step);
        if (wide > pcfk_pkg::SUM_W'(pcfk_pkg::SAT_MAX)) begin
            o_sum = pcfk_pkg::SAT_MAX;
        end else if (wide < pcfk_pkg::SUM_W'(pcfk_pkg::SAT_MIN)) begin
            o_sum = pcfk_pkg::SAT_MIN;
        end else begin
            o_sum = pcfk_pkg::POS_W'(wide);
        end
        n_acc = r_acc;
        if (i_en && i_ctl.valid) begin
            n_acc = i_ctl.last ? '0 : o_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

endmodule

[src/planar_chain_forward_kinematics_top.sv]
// channel  direction  handshake                     payload
// in       input      i_in_valid / o_in_ready       i_joint_angle, i_last_joint
// out      output     o_out_valid / i_out_ready     o_status, o_tip_x, o_tip_y,
//                                                   o_tip_heading, o_heading_cosine,
//                                                   o_heading_sine
// cfg      input      i_cfg_we (no wait)            i_cfg_index, i_cfg_data
//
// one joint angle per cycle while o_in_ready is high; once its last angle is taken, a pose
// result passes through the table read, multiply and output registers before it is valid
// the sine table ROM holds SINE_TABLE_DEPTH + 1 entries with two registered read ports.
// synchronous active-low reset clears the running pose, pipeline and output valid,
// and loads link_count 3 and all link lengths 1.0.
// o_in_ready drops only while a finished pose waits in the output register and
// the next pose's result is ready to leave the multiply stage.
module planar_chain_forward_kinematics_top #(
    parameter int MAX_LINKS        = 4,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [pcfk_pkg::ANG_W-1:0]   i_joint_angle,
    input  logic                                i_last_joint,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_status,
    output logic signed [pcfk_pkg::POS_W-1:0]   o_tip_x,
    output logic signed [pcfk_pkg::POS_W-1:0]   o_tip_y,
    output logic signed [pcfk_pkg::ANG_W-1:0]   o_tip_heading,
    output logic signed [pcfk_pkg::TRIG_W-1:0]  o_heading_cosine,
    output logic signed [pcfk_pkg::TRIG_W-1:0]  o_heading_sine,
    input  logic                                i_cfg_we,
    input  logic [pcfk_pkg::REG_W-1:0]          i_cfg_index,
    input  logic [pcfk_pkg::LEN_W-1:0]          i_cfg_data
);

    localparam int CNT_W  = $clog2(MAX_LINKS + 2);
    localparam int CMP_W  = (CNT_W > pcfk_pkg::LC_W) ? CNT_W : pcfk_pkg::LC_W;
    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int MUL_W  = pcfk_pkg::FRAC_W + IDX_W;

    // configuration
    logic [pcfk_pkg::LC_W-1:0]   r_link_count;
    logic [pcfk_pkg::LEN_W-1:0]  r_len [pcfk_pkg::NUM_LEN];

    // running pose state
    logic [pcfk_pkg::ANG_W-1:0]  r_heading;
    logic [CNT_W-1:0]            r_seen;

    // pipeline
    pcfk_pkg::t_stage_ctl        r_a_ctl;
    logic [1:0]                  r_a_quad;
    logic [pcfk_pkg::ANG_W-1:0]  r_a_heading;
    logic [pcfk_pkg::LEN_W-1:0]  r_a_len;
    pcfk_pkg::t_stage_ctl        r_b_ctl;
    logic [pcfk_pkg::ANG_W-1:0]  r_b_heading;
    logic signed [pcfk_pkg::TRIG_W-1:0] r_b_cos;
    logic signed [pcfk_pkg::TRIG_W-1:0] r_b_sin;

    // output register
    logic                                r_out_valid;
    logic                                r_out_status;
    logic signed [pcfk_pkg::POS_W-1:0]   r_out_x;
    logic signed [pcfk_pkg::POS_W-1:0]   r_out_y;
    logic [pcfk_pkg::ANG_W-1:0]          r_out_heading;
    logic signed [pcfk_pkg::TRIG_W-1:0]  r_out_cos;
    logic signed [pcfk_pkg::TRIG_W-1:0]  r_out_sin;

    logic                        stall;
    logic                        adv;
    logic                        in_take;
    logic [pcfk_pkg::ANG_W-1:0]  heading_new;
    logic [MUL_W-1:0]            idx_prod;
    logic [IDX_W-1:0]            idx;
    logic [IDX_W-1:0]            idx_c;
    logic [CNT_W-1:0]            seen_inc;
    logic                        lc_ok;
    logic                        pose_ok;
    logic [pcfk_pkg::LEN_W-1:0]  len_sel;
    logic [pcfk_pkg::QTAB_W-1:0] rom_a;
    logic [pcfk_pkg::QTAB_W-1:0] rom_b;
    logic [pcfk_pkg::QTAB_W-1:0] sin_mag;
    logic [pcfk_pkg::QTAB_W-1:0] cos_mag;
    logic                        sin_neg;
    logic                        cos_neg;
    logic signed [pcfk_pkg::POS_W-1:0] x_sum;
    logic signed [pcfk_pkg::POS_W-1:0] y_sum;
    logic                        out_load;

    // hold everything only when a pose result would land on a full output register
    assign stall      = r_out_valid && !i_out_ready && r_b_ctl.valid && r_b_ctl.last;
    assign adv        = !stall;
    assign o_in_ready = !stall;
    assign in_take    = i_in_valid && o_in_ready;
    assign out_load   = adv && r_b_ctl.valid && r_b_ctl.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_count <= pcfk_pkg::LC_RESET;
            for (int i = 0; i < pcfk_pkg::NUM_LEN; i++) begin
                r_len[i] <= pcfk_pkg::LEN_RESET;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pcfk_pkg::REG_LINK_COUNT:   r_link_count <= i_cfg_data[pcfk_pkg::LC_W-1:0];
                pcfk_pkg::REG_LENGTH_LINK0: r_len[0] <= i_cfg_data;
                pcfk_pkg::REG_LENGTH_LINK1: r_len[1] <= i_cfg_data;
                pcfk_pkg::REG_LENGTH_LINK2: r_len[2] <= i_cfg_data;
                pcfk_pkg::REG_LENGTH_LINK3: r_len[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // heading update and table addressing for the incoming joint
    always_comb begin
        heading_new = r_heading + $unsigned(i_joint_angle);
        idx_prod    = MUL_W'(heading_new[pcfk_pkg::FRAC_W-1:0]) * MUL_W'(SINE_TABLE_DEPTH);
        idx         = idx_prod[MUL_W-1:pcfk_pkg::FRAC_W];
        idx_c       = IDX_W'(SINE_TABLE_DEPTH) - idx;
        seen_inc    = (CMP_W'(r_seen) < CMP_W'(MAX_LINKS + 1)) ? r_seen + CNT_W'(1) : r_seen;
        lc_ok       = (r_link_count != '0) && (CMP_W'(r_link_count) <= CMP_W'(MAX_LINKS));
        pose_ok     = lc_ok && (CMP_W'(seen_inc) == CMP_W'(r_link_count));
        len_sel     = '0;
        if (CMP_W'(r_seen) < CMP_W'(pcfk_pkg::NUM_LEN) &&
            CMP_W'(r_seen) < CMP_W'(MAX_LINKS) &&
            CMP_W'(r_seen) < CMP_W'(r_link_count)) begin
            len_sel = r_len[r_seen[1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading <= '0;
            r_seen    <= '0;
        end else if (in_take) begin
            r_heading <= i_last_joint ? '0 : heading_new;
            r_seen    <= i_last_joint ? '0 : seen_inc;
        end
    end

    pcfk_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .i_clk    (i_clk),
        .i_en     (adv),
        .i_addr_a (idx),
        .i_addr_b (idx_c),
        .o_data_a (rom_a),
        .o_data_b (rom_b)
    );

    // table read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
        end else if (adv) begin
            r_a_ctl <= '{valid: in_take, last: i_last_joint, ok: pose_ok};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_quad    <= heading_new[pcfk_pkg::ANG_W-1:pcfk_pkg::ANG_W-2];
            r_a_heading <= heading_new;
            r_a_len     <= len_sel;
        end
    end

    // quadrant folding
    always_comb begin
        unique case (r_a_quad)
            2'd0: begin
                sin_mag = rom_a; sin_neg = 1'b0; cos_mag = rom_b; cos_neg = 1'b0;
            end
            2'd1: begin
                sin_mag = rom_b; sin_neg = 1'b0; cos_mag = rom_a; cos_neg = 1'b1;
            end
            2'd2: begin
                sin_mag = rom_a; sin_neg = 1'b1; cos_mag = rom_b; cos_neg = 1'b1;
            end
            default: begin
                sin_mag = rom_b; sin_neg = 1'b1; cos_mag = rom_a; cos_neg = 1'b0;
            end
        endcase
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl <= '0;
        end else if (adv) begin
            r_b_ctl <= r_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_heading <= r_a_heading;
            r_b_cos     <= cos_neg ? -$signed(pcfk_pkg::TRIG_W'(cos_mag))
                                   :  $signed(pcfk_pkg::TRIG_W'(cos_mag));
            r_b_sin     <= sin_neg ? -$signed(pcfk_pkg::TRIG_W'(sin_mag))
                                   :  $signed(pcfk_pkg::TRIG_W'(sin_mag));
        end
    end

    pcfk_axis u_axis_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_len   (r_a_len),
        .i_mag   (cos_mag),
        .i_neg   (cos_neg),
        .i_ctl   (r_b_ctl),
        .o_sum   (x_sum)
    );

    pcfk_axis u_axis_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_len   (r_a_len),
        .i_mag   (sin_mag),
        .i_neg   (sin_neg),
        .i_ctl   (r_b_ctl),
        .o_sum   (y_sum)
    );

    // output register, identity pose on a count mismatch or an invalid link count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status  <= !r_b_ctl.ok;
            r_out_x       <= r_b_ctl.ok ? x_sum : '0;
            r_out_y       <= r_b_ctl.ok ? y_sum : '0;
            r_out_heading <= r_b_ctl.ok ? r_b_heading : '0;
            r_out_cos     <= r_b_ctl.ok ? r_b_cos
                                        : $signed(pcfk_pkg::TRIG_W'(pcfk_pkg::ONE_Q14));
            r_out_sin     <= r_b_ctl.ok ? r_b_sin : '0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_tip_x          = r_out_x;
    assign o_tip_y          = r_out_y;
    assign o_tip_heading    = $signed(r_out_heading);
    assign o_heading_cosine = r_out_cos;
    assign o_heading_sine   = r_out_sin;

endmodule
